[design/sorted_set_jaccard_index_macros.svh]
// Assertion macros for the sorted-set Jaccard index block.
// Used by the top level; no other dependencies.
`ifndef SORTED_SET_JACCARD_INDEX_MACROS_SVH
`define SORTED_SET_JACCARD_INDEX_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define SJACC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sjacc assertion failed");
// Next-cycle implication, held off during reset.
`define SJACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sjacc assertion failed");
`else
`define SJACC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SJACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/sjacc_pkg.sv]
// Shared types, constants and helpers for the sorted-set Jaccard index block.
// No dependencies; used by the top level, the controller and the datapath.
package sjacc_pkg;

  localparam int unsigned DEPTH         = 1024;
  localparam int unsigned ELEMENT_WIDTH = 32;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ElemFldW = 32;
  localparam int unsigned InterW   = 11;
  localparam int unsigned UnionW   = 12;
  localparam int unsigned RatioW   = 17;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned RemW  = CntW + 2;
  localparam int unsigned StepW = $clog2(RatioW);

  typedef logic [AddrW-1:0]         addr_t;
  typedef logic [CntW-1:0]          cnt_t;
  typedef logic [SumW-1:0]          sum_t;
  typedef logic [RemW-1:0]          rem_t;
  typedef logic [StepW-1:0]         step_t;
  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [InterW-1:0]        inter_cnt_t;
  typedef logic [UnionW-1:0]        union_cnt_t;
  typedef logic [RatioW-1:0]        ratio_t;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]     command;
    logic [ElemFldW-1:0] element;
  } in_item_t;

  typedef struct packed {
    inter_cnt_t intersection_count;
    union_cnt_t union_count;
    ratio_t     jaccard_ratio;
    logic       overflowed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic start;
    logic walk;
    logic div_init;
    logic div_step;
    logic publish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } dp_stat_t;

  // Zero-extend or truncate the element field to the stored width.
  function automatic elem_t fit_elem(input logic [ElemFldW-1:0] e);
    logic [ELEMENT_WIDTH+ElemFldW-1:0] wide;
    wide = {{ELEMENT_WIDTH{1'b0}}, e};
    return wide[ELEMENT_WIDTH-1:0];
  endfunction

endpackage

[design/sorted_set_jaccard_index.sv]
// Top level of the sorted-set Jaccard index block.
// Depends on sjacc_pkg, sjacc_ctrl, sjacc_dp and the assertion macro header.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   in_data_i  (command, element)
//   out      out  out_valid_o/out_stall_i out_data_o (intersection, union, ratio, ovf)
//
// Pushes stream one transfer per clock while the controller is idle.
// A finish runs a merge walk, set by one registered read per list RAM per step,
// then the one-bit-per-clock divider and a publish step.
// Reset clears the counts, the overflow flag, the controller and the result valid;
// the list RAMs need no clearing since only entries below each count are used.
// A finish is stalled while the previous result still waits; pushes keep flowing.
`include "sorted_set_jaccard_index_macros.svh"

module sorted_set_jaccard_index (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sjacc_pkg::in_item_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sjacc_pkg::out_item_t   out_data_o
);

  sjacc_pkg::dp_cmd_t  dp_cmd;
  sjacc_pkg::dp_stat_t dp_stat;

  // Controller: owns the handshake on the input side and the sequencing.
  sjacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_data_i.command),
    .stat_i     (dp_stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  // Datapath: list storage, merge, divide and the result register.
  sjacc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .element_i   (in_data_i.element),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A finish transfer is only taken with the result register empty.
  `SJACC_ASSERT_IMPL(a_finish_out_free, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.command == sjacc_pkg::CMD_FINISH), !out_valid_o)

  // After a finish transfer the block is busy computing.
  `SJACC_ASSERT_NEXT(a_finish_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.command == sjacc_pkg::CMD_FINISH), in_stall_o)

  // A published ratio never exceeds one and intersection never exceeds union.
  `SJACC_ASSERT_IMPL(a_result_sane, clk_i, rst_ni, out_valid_o, (out_data_o.jaccard_ratio <= 17'h10000) && ({1'b0, out_data_o.intersection_count} <= out_data_o.union_count))

endmodule

[design/sjacc_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module sjacc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                          wdata_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sjacc_ctrl.sv]
// Controller: sequences load, merge walk, divide and publish.
// Depends on sjacc_pkg.
module sjacc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [sjacc_pkg::CmdW-1:0]    command_i,
  input  sjacc_pkg::dp_stat_t           stat_i,
  output logic                          in_stall_o,
  output sjacc_pkg::dp_cmd_t            cmd_o
);

  sjacc_pkg::state_e state_q, state_d;
  sjacc_pkg::step_t  step_q, step_d;
  logic              accept;
  logic              is_finish;
  logic              div_last;

  assign is_finish  = (command_i == sjacc_pkg::CMD_FINISH);
  // Stall every transfer while busy; hold a finish back while the previous result still waits.
  assign in_stall_o = (state_q != sjacc_pkg::ST_IDLE) || (is_finish && stat_i.out_busy);
  assign accept     = in_valid_i && !in_stall_o;
  assign div_last   = (step_q == sjacc_pkg::step_t'(sjacc_pkg::RatioW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sjacc_pkg::ST_IDLE: begin
        if (accept && is_finish) state_d = sjacc_pkg::ST_WALK;
      end
      sjacc_pkg::ST_WALK: begin
        if (stat_i.walk_done) state_d = sjacc_pkg::ST_DIV;
      end
      sjacc_pkg::ST_DIV: begin
        if (div_last) state_d = sjacc_pkg::ST_DONE;
      end
      sjacc_pkg::ST_DONE: begin
        state_d = sjacc_pkg::ST_IDLE;
      end
      default: state_d = sjacc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      sjacc_pkg::ST_IDLE: begin
        cmd_o.push_a = accept && (command_i == sjacc_pkg::CMD_PUSH_A);
        cmd_o.push_b = accept && (command_i == sjacc_pkg::CMD_PUSH_B);
        cmd_o.start  = accept && is_finish;
      end
      sjacc_pkg::ST_WALK: begin
        cmd_o.walk     = 1'b1;
        cmd_o.div_init = stat_i.walk_done;
      end
      sjacc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      sjacc_pkg::ST_DONE: begin
        cmd_o.publish = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign step_d = (state_q == sjacc_pkg::ST_DIV) ? sjacc_pkg::step_t'(step_q + 1'b1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sjacc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[design/sjacc_dp.sv]
// Datapath: list RAMs, counts, merge walk, radix-2 divider, result register.
// Depends on sjacc_pkg and sjacc_ram.
module sjacc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sjacc_pkg::ElemFldW-1:0]    element_i,
  input  sjacc_pkg::dp_cmd_t                cmd_i,
  output sjacc_pkg::dp_stat_t               stat_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sjacc_pkg::out_item_t              out_data_o
);

  sjacc_pkg::cnt_t   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  sjacc_pkg::cnt_t   i_q, i_d, j_q, j_d, inter_q, inter_d;
  sjacc_pkg::sum_t   uni_q, uni_d;
  sjacc_pkg::rem_t   rem_q, rem_d, rem_diff;
  sjacc_pkg::ratio_t quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  sjacc_pkg::out_item_t out_q, out_d;

  logic              full_a, full_b, we_a, we_b, active, rem_ge;
  sjacc_pkg::addr_t  addr_a, addr_b;
  sjacc_pkg::elem_t  wdata, rd_a, rd_b;

  assign full_a = (cnt_a_q == sjacc_pkg::cnt_t'(sjacc_pkg::DEPTH));
  assign full_b = (cnt_b_q == sjacc_pkg::cnt_t'(sjacc_pkg::DEPTH));
  assign we_a   = cmd_i.push_a && !full_a;
  assign we_b   = cmd_i.push_b && !full_b;
  assign wdata  = sjacc_pkg::fit_elem(element_i);

  // Read address follows the next walk index so the registered read data lines up with i_q and j_q in the next cycle.
  assign addr_a = we_a ? cnt_a_q[sjacc_pkg::AddrW-1:0] : i_d[sjacc_pkg::AddrW-1:0];
  assign addr_b = we_b ? cnt_b_q[sjacc_pkg::AddrW-1:0] : j_d[sjacc_pkg::AddrW-1:0];

  sjacc_ram #(
    .Width (sjacc_pkg::ELEMENT_WIDTH),
    .Depth (sjacc_pkg::DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .addr_i  (addr_a),
    .wdata_i (wdata),
    .rdata_o (rd_a)
  );

  sjacc_ram #(
    .Width (sjacc_pkg::ELEMENT_WIDTH),
    .Depth (sjacc_pkg::DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .addr_i  (addr_b),
    .wdata_i (wdata),
    .rdata_o (rd_b)
  );

  assign active = (i_q < cnt_a_q) && (j_q < cnt_b_q);

  // Merge walk
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    inter_d = inter_q;
    if (cmd_i.start) begin
      i_d     = '0;
      j_d     = '0;
      inter_d = '0;
    end else if (cmd_i.walk && active) begin
      if (rd_a < rd_b) begin
        i_d = sjacc_pkg::cnt_t'(i_q + 1'b1);
      end else if (rd_b < rd_a) begin
        j_d = sjacc_pkg::cnt_t'(j_q + 1'b1);
      end else begin
        i_d     = sjacc_pkg::cnt_t'(i_q + 1'b1);
        j_d     = sjacc_pkg::cnt_t'(j_q + 1'b1);
        inter_d = sjacc_pkg::cnt_t'(inter_q + 1'b1);
      end
    end
  end

  // Counts and sticky overflow
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    if (cmd_i.publish) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (we_a) cnt_a_d = sjacc_pkg::cnt_t'(cnt_a_q + 1'b1);
      if (we_b) cnt_b_d = sjacc_pkg::cnt_t'(cnt_b_q + 1'b1);
      if ((cmd_i.push_a && full_a) || (cmd_i.push_b && full_b)) ovf_d = 1'b1;
    end
  end

  // Restoring divider, one quotient bit per cycle: (inter << 16) / union
  assign rem_ge   = (rem_q >= sjacc_pkg::rem_t'(uni_q));
  assign rem_diff = rem_ge ? sjacc_pkg::rem_t'(rem_q - sjacc_pkg::rem_t'(uni_q)) : rem_q;

  always_comb begin
    uni_d = uni_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_init) begin
      uni_d = sjacc_pkg::sum_t'({1'b0, cnt_a_q} + {1'b0, cnt_b_q} - {1'b0, inter_q});
      rem_d = sjacc_pkg::rem_t'(inter_q);
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = {rem_diff[sjacc_pkg::RemW-2:0], 1'b0};
      quo_d = {quo_q[sjacc_pkg::RatioW-2:0], rem_ge};
    end
  end

  // Result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cmd_i.publish) begin
      out_d.intersection_count = sjacc_pkg::inter_cnt_t'(inter_q);
      out_d.union_count        = sjacc_pkg::union_cnt_t'(uni_q);
      out_d.jaccard_ratio      = (uni_q == '0) ? '0 : quo_q;
      out_d.overflowed         = ovf_q;
      out_valid_d              = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    inter_q <= inter_d;
    uni_q   <= uni_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    out_q   <= out_d;
  end

  assign stat_o.walk_done = !active;
  assign stat_o.out_busy  = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule
